// ----- rtl/core/wms_pkg.sv -----
// Shared types and constants for the waypoint motion sequencer.
package wms_pkg;

    localparam int WMS_TABLE_DEPTH = 64;
    localparam logic [15:0] WMS_TIMEOUT_RESET = 16'd1000;

    typedef enum logic [2:0] {
        OP_CLEAR  = 3'd0,
        OP_APPEND = 3'd1,
        OP_START  = 3'd2,
        OP_CANCEL = 3'd3,
        OP_ESTOP  = 3'd4,
        OP_TICK   = 3'd5
    } wms_op_t;

    typedef enum logic [0:0] {
        CFG_TOLERANCE = 1'b0,
        CFG_TIMEOUT   = 1'b1
    } wms_cfg_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_LAUNCH
    } wms_state_t;

    typedef struct packed {
        logic signed [31:0] linear;
        logic signed [31:0] rotation;
        logic [15:0]        dwell;
    } wms_entry_t;

endpackage

// ----- rtl/core/wms_table.sv -----
// Waypoint table: single write port, one registered read port.
module wms_table
    import wms_pkg::*;
#(
    parameter int TABLE_DEPTH = WMS_TABLE_DEPTH,
    localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1
) (
    input  logic          aclk,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  wms_entry_t    wr_data,
    input  logic          rd_en,
    input  logic [AW-1:0] rd_addr,
    output wms_entry_t    rd_data
);

    wms_entry_t mem [TABLE_DEPTH];
    wms_entry_t rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ----- rtl/core/wms_ctrl.sv -----
// Sequencer control: operation decode, timers, cursor and result register.
module wms_ctrl
    import wms_pkg::*;
#(
    parameter int TABLE_DEPTH = WMS_TABLE_DEPTH,
    localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1,
    localparam int CW = $clog2(TABLE_DEPTH + 1)
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_we,
    input  logic [0:0]         cfg_index,
    input  logic [15:0]        cfg_data,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [2:0]         s_operation,
    input  logic signed [31:0] s_wp_linear,
    input  logic signed [31:0] s_wp_rotation,
    input  logic [15:0]        s_wp_dwell,
    input  logic signed [31:0] s_linear_position,
    input  logic               s_rotation_busy,
    output logic               m_valid,
    input  logic               m_ready,
    output logic               m_move_issued,
    output logic signed [31:0] m_linear_target,
    output logic signed [31:0] m_rotation_target,
    output logic               m_running,
    output logic               m_dwelling,
    output logic               m_linear_busy,
    output logic               m_stop_issued,
    output logic [6:0]         m_point_index,
    output logic               tbl_wr_en,
    output logic [AW-1:0]      tbl_wr_addr,
    output wms_entry_t         tbl_wr_data,
    output logic               tbl_rd_en,
    output logic [AW-1:0]      tbl_rd_addr,
    input  wms_entry_t         tbl_rd_data
);

    localparam logic [CW-1:0] DEPTH_C = CW'(TABLE_DEPTH);

    wms_state_t state_reg, state_next;

    logic [15:0] tol_reg, timeout_reg;

    logic [2:0]         op_reg;
    wms_entry_t         wp_reg;
    logic signed [31:0] pos_reg;
    logic               rot_busy_reg;

    logic [CW-1:0]      count_reg, count_next;
    logic [CW-1:0]      cursor_reg, cursor_next;
    logic               active_reg, active_next;
    logic               dwell_reg, dwell_next;
    logic [15:0]        dwell_left_reg, dwell_left_next;
    logic               moving_reg, moving_next;
    logic [15:0]        time_left_reg, time_left_next;
    logic signed [31:0] lin_tgt_reg, lin_tgt_next;
    logic signed [31:0] rot_tgt_reg, rot_tgt_next;

    logic               m_valid_reg;
    logic               moved_out_reg, stop_out_reg;
    logic signed [31:0] lin_out_reg, rot_out_reg;
    logic               run_out_reg, dwell_out_reg, busy_out_reg;
    logic [6:0]         idx_out_reg;

    logic out_free, finish, moved, stopped, advance;
    logic [CW-1:0] cur_inc;
    logic [15:0] tl_dec, dl_dec;
    logic signed [32:0] diff;
    logic [32:0] abs_diff;
    logic in_tol, mv_after;
    logic [CW+6:0] idx_ext;

    assign out_free = !m_valid_reg || m_ready;
    assign cur_inc  = cursor_reg + CW'(1);
    assign diff     = {pos_reg[31], pos_reg} - {lin_tgt_reg[31], lin_tgt_reg};
    assign abs_diff = diff[32] ? 33'(-diff) : 33'(diff);
    assign in_tol   = abs_diff <= {17'd0, tol_reg};
    assign tl_dec   = (moving_reg && time_left_reg != 16'd0) ? time_left_reg - 16'd1
                                                             : time_left_reg;
    assign dl_dec   = (dwell_reg && dwell_left_reg != 16'd0) ? dwell_left_reg - 16'd1
                                                             : dwell_left_reg;
    assign mv_after = moving_reg && !(in_tol || tl_dec == 16'd0);
    assign idx_ext  = {7'd0, cursor_next};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tol_reg     <= 16'd0;
            timeout_reg <= WMS_TIMEOUT_RESET;
        end else if (cfg_we) begin
            unique case (wms_cfg_t'(cfg_index))
                CFG_TOLERANCE: tol_reg     <= cfg_data;
                CFG_TIMEOUT:   timeout_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (state_reg == ST_IDLE && s_valid) begin
            op_reg       <= s_operation;
            wp_reg       <= '{linear: s_wp_linear, rotation: s_wp_rotation,
                              dwell: s_wp_dwell};
            pos_reg      <= s_linear_position;
            rot_busy_reg <= s_rotation_busy;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            count_reg      <= '0;
            cursor_reg     <= '0;
            active_reg     <= 1'b0;
            dwell_reg      <= 1'b0;
            dwell_left_reg <= 16'd0;
            moving_reg     <= 1'b0;
            time_left_reg  <= 16'd0;
            lin_tgt_reg    <= 32'sd0;
            rot_tgt_reg    <= 32'sd0;
        end else begin
            state_reg      <= state_next;
            count_reg      <= count_next;
            cursor_reg     <= cursor_next;
            active_reg     <= active_next;
            dwell_reg      <= dwell_next;
            dwell_left_reg <= dwell_left_next;
            moving_reg     <= moving_next;
            time_left_reg  <= time_left_next;
            lin_tgt_reg    <= lin_tgt_next;
            rot_tgt_reg    <= rot_tgt_next;
        end
    end

    always_comb begin
        state_next      = state_reg;
        count_next      = count_reg;
        cursor_next     = cursor_reg;
        active_next     = active_reg;
        dwell_next      = dwell_reg;
        dwell_left_next = dwell_left_reg;
        moving_next     = moving_reg;
        time_left_next  = time_left_reg;
        lin_tgt_next    = lin_tgt_reg;
        rot_tgt_next    = rot_tgt_reg;
        s_ready         = 1'b0;
        finish          = 1'b0;
        moved           = 1'b0;
        stopped         = 1'b0;
        advance         = 1'b0;
        tbl_wr_en       = 1'b0;
        tbl_wr_addr     = count_reg[AW-1:0];
        tbl_wr_data     = wp_reg;
        tbl_rd_en       = 1'b0;
        tbl_rd_addr     = cursor_reg[AW-1:0];

        unique case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    tbl_rd_en   = 1'b1;
                    tbl_rd_addr = (s_operation == OP_START) ? '0 : cursor_reg[AW-1:0];
                    state_next  = ST_EXEC;
                end
            end
            ST_EXEC: begin
                if (out_free) begin
                    finish = 1'b1;
                    unique case (op_reg)
                        OP_CLEAR: begin
                            count_next  = '0;
                            cursor_next = '0;
                            active_next = 1'b0;
                            dwell_next  = 1'b0;
                        end
                        OP_APPEND: begin
                            if (count_reg < DEPTH_C) begin
                                tbl_wr_en  = 1'b1;
                                count_next = count_reg + CW'(1);
                            end
                        end
                        OP_START: begin
                            cursor_next = '0;
                            dwell_next  = 1'b0;
                            active_next = count_reg != '0;
                            if (count_reg != '0) begin
                                lin_tgt_next   = tbl_rd_data.linear;
                                rot_tgt_next   = tbl_rd_data.rotation;
                                moving_next    = 1'b1;
                                time_left_next = timeout_reg;
                                moved          = 1'b1;
                            end
                        end
                        OP_CANCEL: begin
                            active_next = 1'b0;
                            dwell_next  = 1'b0;
                            stopped     = 1'b1;
                        end
                        OP_ESTOP: begin
                            active_next = 1'b0;
                            dwell_next  = 1'b0;
                            moving_next = 1'b0;
                            stopped     = 1'b1;
                        end
                        OP_TICK: begin
                            time_left_next  = tl_dec;
                            dwell_left_next = dl_dec;
                            moving_next     = mv_after;
                            if (active_reg) begin
                                if (dwell_reg) begin
                                    if (dl_dec == 16'd0) begin
                                        dwell_next = 1'b0;
                                        advance    = 1'b1;
                                    end
                                end else if (!rot_busy_reg && !mv_after) begin
                                    if (tbl_rd_data.dwell != 16'd0) begin
                                        dwell_next      = 1'b1;
                                        dwell_left_next = tbl_rd_data.dwell;
                                    end else begin
                                        advance = 1'b1;
                                    end
                                end
                            end
                            if (advance) begin
                                cursor_next = cur_inc;
                                if (cur_inc >= count_reg) begin
                                    active_next = 1'b0;
                                end else begin
                                    // second table read for the next waypoint
                                    finish      = 1'b0;
                                    tbl_rd_en   = 1'b1;
                                    tbl_rd_addr = cur_inc[AW-1:0];
                                    state_next  = ST_LAUNCH;
                                end
                            end
                        end
                        default: ;
                    endcase
                    if (finish) begin
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_LAUNCH: begin
                if (out_free) begin
                    finish         = 1'b1;
                    lin_tgt_next   = tbl_rd_data.linear;
                    rot_tgt_next   = tbl_rd_data.rotation;
                    moving_next    = 1'b1;
                    time_left_next = timeout_reg;
                    moved          = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (finish) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (finish) begin
            moved_out_reg <= moved;
            stop_out_reg  <= stopped;
            lin_out_reg   <= lin_tgt_next;
            rot_out_reg   <= rot_tgt_next;
            run_out_reg   <= active_next;
            dwell_out_reg <= dwell_next;
            busy_out_reg  <= moving_next;
            idx_out_reg   <= idx_ext[6:0];
        end
    end

    assign m_valid           = m_valid_reg;
    assign m_move_issued     = moved_out_reg;
    assign m_linear_target   = lin_out_reg;
    assign m_rotation_target = rot_out_reg;
    assign m_running         = run_out_reg;
    assign m_dwelling        = dwell_out_reg;
    assign m_linear_busy     = busy_out_reg;
    assign m_stop_issued     = stop_out_reg;
    assign m_point_index     = idx_out_reg;

endmodule

// ----- rtl/core/waypoint_motion_sequencer.sv -----
// Waypoint motion sequencer top level: control logic and waypoint table.
// Each transfer in produces exactly one result transfer. An accepted item
// takes the registered table read, then the state update that loads the
// result; a tick that advances to the next waypoint needs a second table
// read before its result is loaded. The update waits while the result
// side is full, and a new item is accepted in the cycle after the result is
// loaded, so one item is done before the next is taken. The table is a
// single memory of TABLE_DEPTH entries with one write and one read port and
// needs no clearing after reset; only appended entries are ever used.
module waypoint_motion_sequencer
    import wms_pkg::*;
#(
    parameter int TABLE_DEPTH = WMS_TABLE_DEPTH
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_we,
    input  logic [0:0]         cfg_index,
    input  logic [15:0]        cfg_data,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [2:0]         s_operation,
    input  logic signed [31:0] s_wp_linear,
    input  logic signed [31:0] s_wp_rotation,
    input  logic [15:0]        s_wp_dwell,
    input  logic signed [31:0] s_linear_position,
    input  logic               s_rotation_busy,
    output logic               m_valid,
    input  logic               m_ready,
    output logic               m_move_issued,
    output logic signed [31:0] m_linear_target,
    output logic signed [31:0] m_rotation_target,
    output logic               m_running,
    output logic               m_dwelling,
    output logic               m_linear_busy,
    output logic               m_stop_issued,
    output logic [6:0]         m_point_index
);

    localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

    logic          tbl_wr_en, tbl_rd_en;
    logic [AW-1:0] tbl_wr_addr, tbl_rd_addr;
    wms_entry_t    tbl_wr_data, tbl_rd_data;

    wms_ctrl #(.TABLE_DEPTH(TABLE_DEPTH)) u_ctrl (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .cfg_we            (cfg_we),
        .cfg_index         (cfg_index),
        .cfg_data          (cfg_data),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_operation       (s_operation),
        .s_wp_linear       (s_wp_linear),
        .s_wp_rotation     (s_wp_rotation),
        .s_wp_dwell        (s_wp_dwell),
        .s_linear_position (s_linear_position),
        .s_rotation_busy   (s_rotation_busy),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_move_issued     (m_move_issued),
        .m_linear_target   (m_linear_target),
        .m_rotation_target (m_rotation_target),
        .m_running         (m_running),
        .m_dwelling        (m_dwelling),
        .m_linear_busy     (m_linear_busy),
        .m_stop_issued     (m_stop_issued),
        .m_point_index     (m_point_index),
        .tbl_wr_en         (tbl_wr_en),
        .tbl_wr_addr       (tbl_wr_addr),
        .tbl_wr_data       (tbl_wr_data),
        .tbl_rd_en         (tbl_rd_en),
        .tbl_rd_addr       (tbl_rd_addr),
        .tbl_rd_data       (tbl_rd_data)
    );

    wms_table #(.TABLE_DEPTH(TABLE_DEPTH)) u_table (
        .aclk    (aclk),
        .wr_en   (tbl_wr_en),
        .wr_addr (tbl_wr_addr),
        .wr_data (tbl_wr_data),
        .rd_en   (tbl_rd_en),
        .rd_addr (tbl_rd_addr),
        .rd_data (tbl_rd_data)
    );

endmodule

// ----- tb/sv/tb.sv -----
// Testbench for the waypoint motion sequencer: directed and random commands checked per transfer.
module tb;
    import wms_pkg::*;

    localparam int          STALL_LIMIT   = 5000;
    localparam int          HOLD_CYCLES   = 400;
    localparam int          SETTLE_CYCLES = 8;
    localparam int          MAX_PRINTS    = 40;
    localparam logic [2:0]  OP_SPARE_6    = 3'd6;
    localparam logic [2:0]  OP_SPARE_7    = 3'd7;

    typedef struct packed {
        logic [2:0]         op;
        logic signed [31:0] wp_lin;
        logic signed [31:0] wp_rot;
        logic [15:0]        wp_dwell;
        logic signed [31:0] pos;
        logic               rot_busy;
    } command_t;

    typedef struct packed {
        logic               moved;
        logic signed [31:0] lin_tgt;
        logic signed [31:0] rot_tgt;
        logic               running;
        logic               dwelling;
        logic               lin_busy;
        logic               stopped;
        logic [6:0]         index;
    } status_t;

    logic               aclk = 1'b0;
    logic               aresetn = 1'b0;
    logic               cfg_we = 1'b0;
    logic [0:0]         cfg_index = CFG_TOLERANCE;
    logic [15:0]        cfg_data = '0;
    logic               s_valid = 1'b0;
    logic               s_ready;
    logic [2:0]         s_operation = OP_CLEAR;
    logic signed [31:0] s_wp_linear = '0;
    logic signed [31:0] s_wp_rotation = '0;
    logic [15:0]        s_wp_dwell = '0;
    logic signed [31:0] s_linear_position = '0;
    logic               s_rotation_busy = 1'b0;
    logic               m_valid;
    logic               m_ready = 1'b0;
    logic               m_move_issued;
    logic signed [31:0] m_linear_target;
    logic signed [31:0] m_rotation_target;
    logic               m_running;
    logic               m_dwelling;
    logic               m_linear_busy;
    logic               m_stop_issued;
    logic [6:0]         m_point_index;

    waypoint_motion_sequencer dut (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .cfg_we            (cfg_we),
        .cfg_index         (cfg_index),
        .cfg_data          (cfg_data),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_operation       (s_operation),
        .s_wp_linear       (s_wp_linear),
        .s_wp_rotation     (s_wp_rotation),
        .s_wp_dwell        (s_wp_dwell),
        .s_linear_position (s_linear_position),
        .s_rotation_busy   (s_rotation_busy),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_move_issued     (m_move_issued),
        .m_linear_target   (m_linear_target),
        .m_rotation_target (m_rotation_target),
        .m_running         (m_running),
        .m_dwelling        (m_dwelling),
        .m_linear_busy     (m_linear_busy),
        .m_stop_issued     (m_stop_issued),
        .m_point_index     (m_point_index)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // sequencer state as predicted
    logic signed [31:0] tbl_linear   [WMS_TABLE_DEPTH];
    logic signed [31:0] tbl_rotation [WMS_TABLE_DEPTH];
    logic [15:0]        tbl_dwell    [WMS_TABLE_DEPTH];
    int unsigned        pt_count = 0;
    int unsigned        pt_cursor = 0;
    logic               run_flag = 1'b0;
    logic               dwell_on = 1'b0;
    logic [15:0]        dwell_left = '0;
    logic               lin_moving = 1'b0;
    logic [15:0]        lin_left = '0;
    logic signed [31:0] tgt_linear = '0;
    logic signed [31:0] tgt_rotation = '0;
    logic [15:0]        tol_reg = '0;
    logic [15:0]        timeout_reg = WMS_TIMEOUT_RESET;

    status_t pending_results[$];
    int      items_sent = 0;
    int      error_count = 0;
    int      send_idle_pct = 33;
    int      recv_idle_pct = 61;
    bit      hold_request = 1'b0;
    int      hold_left = 0;
    int      stall_cycles = 0;

    function automatic void launch_waypoint(int unsigned idx);
        int unsigned k;
        k = (idx < WMS_TABLE_DEPTH) ? idx : 0;
        tgt_linear   = tbl_linear[k];
        tgt_rotation = tbl_rotation[k];
        lin_moving   = 1'b1;
        lin_left     = timeout_reg;
    endfunction

    function automatic logic advance_waypoint();
        pt_cursor++;
        if (pt_cursor >= pt_count) begin
            run_flag = 1'b0;
            return 1'b0;
        end
        launch_waypoint(pt_cursor);
        return 1'b1;
    endfunction

    function automatic status_t predict_status(command_t c);
        status_t     r;
        longint      gap;
        int unsigned k;
        r = '0;
        case (c.op)
            OP_CLEAR: begin
                pt_count  = 0;
                pt_cursor = 0;
                run_flag  = 1'b0;
                dwell_on  = 1'b0;
            end
            OP_APPEND: begin
                if (pt_count < WMS_TABLE_DEPTH) begin
                    tbl_linear[pt_count]   = c.wp_lin;
                    tbl_rotation[pt_count] = c.wp_rot;
                    tbl_dwell[pt_count]    = c.wp_dwell;
                    pt_count++;
                end
            end
            OP_START: begin
                pt_cursor = 0;
                dwell_on  = 1'b0;
                run_flag  = (pt_count > 0);
                if (run_flag) begin
                    launch_waypoint(0);
                    r.moved = 1'b1;
                end
            end
            OP_CANCEL: begin
                run_flag  = 1'b0;
                dwell_on  = 1'b0;
                r.stopped = 1'b1;
            end
            OP_ESTOP: begin
                run_flag   = 1'b0;
                dwell_on   = 1'b0;
                lin_moving = 1'b0;
                r.stopped  = 1'b1;
            end
            OP_TICK: begin
                if (lin_moving && lin_left != 0) lin_left--;
                if (dwell_on && dwell_left != 0) dwell_left--;
                if (lin_moving) begin
                    gap = longint'($signed(c.pos)) - longint'($signed(tgt_linear));
                    if (gap < 0) gap = -gap;
                    if (gap <= longint'(tol_reg) || lin_left == 0) lin_moving = 1'b0;
                end
                if (run_flag) begin
                    if (dwell_on) begin
                        if (dwell_left == 0) begin
                            dwell_on = 1'b0;
                            r.moved  = advance_waypoint();
                        end
                    end else if (!c.rot_busy && !lin_moving) begin
                        k = (pt_cursor < WMS_TABLE_DEPTH) ? pt_cursor : 0;
                        if (tbl_dwell[k] != 0) begin
                            dwell_on   = 1'b1;
                            dwell_left = tbl_dwell[k];
                        end else begin
                            r.moved = advance_waypoint();
                        end
                    end
                end
            end
            default: ;
        endcase
        r.lin_tgt  = tgt_linear;
        r.rot_tgt  = tgt_rotation;
        r.running  = run_flag;
        r.dwelling = dwell_on;
        r.lin_busy = lin_moving;
        r.index    = pt_cursor[6:0];
        return r;
    endfunction

    task automatic report_mismatch(string msg);
        error_count++;
        if (error_count <= MAX_PRINTS) $display("%0t: mismatch: %s", $time, msg);
    endtask

    task automatic check_field(string name, logic [31:0] got, logic [31:0] want);
        if (got !== want)
            report_mismatch($sformatf("%s got %h expected %h", name, got, want));
    endtask

    always @(posedge aclk) begin
        status_t want;
        if (aresetn && m_valid === 1'b1 && m_ready) begin
            if (pending_results.size() == 0) begin
                report_mismatch("result transfer with nothing expected");
            end else begin
                want = pending_results.pop_front();
                check_field("move_issued", 32'(m_move_issued), 32'(want.moved));
                check_field("linear_target", 32'(m_linear_target), 32'(want.lin_tgt));
                check_field("rotation_target", 32'(m_rotation_target), 32'(want.rot_tgt));
                check_field("running", 32'(m_running), 32'(want.running));
                check_field("dwelling", 32'(m_dwelling), 32'(want.dwelling));
                check_field("linear_busy", 32'(m_linear_busy), 32'(want.lin_busy));
                check_field("stop_issued", 32'(m_stop_issued), 32'(want.stopped));
                check_field("point_index", 32'(m_point_index), 32'(want.index));
            end
        end
    end

    // watchdog: cycles without any transfer
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready === 1'b1) || (m_valid === 1'b1 && m_ready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles + 1 >= STALL_LIMIT) begin
            $display("tb: failure");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    always @(negedge aclk) begin
        if (hold_request) begin
            hold_left    = HOLD_CYCLES;
            hold_request = 1'b0;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    function automatic command_t random_cmd(logic [2:0] op);
        command_t c;
        c.op       = op;
        c.wp_lin   = $urandom;
        c.wp_rot   = $urandom;
        c.wp_dwell = 16'($urandom);
        c.pos      = $urandom;
        c.rot_busy = 1'($urandom_range(1));
        return c;
    endfunction

    // position around the current target, reaching just past the tolerance
    function automatic logic signed [31:0] near_position();
        int unsigned off;
        off = $urandom_range(int'(tol_reg) + 2, 0);
        if ($urandom_range(1)) return tgt_linear + off;
        return tgt_linear - off;
    endfunction

    task automatic send_command(command_t c);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid           <= 1'b1;
        s_operation       <= c.op;
        s_wp_linear       <= c.wp_lin;
        s_wp_rotation     <= c.wp_rot;
        s_wp_dwell        <= c.wp_dwell;
        s_linear_position <= c.pos;
        s_rotation_busy   <= c.rot_busy;
        @(posedge aclk);
        while (s_ready !== 1'b1) @(posedge aclk);
        pending_results.push_back(predict_status(c));
        items_sent++;
        @(negedge aclk);
    endtask

    task automatic send_op(logic [2:0] op);
        send_command(random_cmd(op));
    endtask

    task automatic send_append(logic signed [31:0] lin, logic signed [31:0] rot,
                               logic [15:0] dwell);
        command_t c;
        c          = random_cmd(OP_APPEND);
        c.wp_lin   = lin;
        c.wp_rot   = rot;
        c.wp_dwell = dwell;
        send_command(c);
    endtask

    task automatic send_tick(logic signed [31:0] pos, logic busy);
        command_t c;
        c          = random_cmd(OP_TICK);
        c.pos      = pos;
        c.rot_busy = busy;
        send_command(c);
    endtask

    task automatic wait_idle();
        s_valid <= 1'b0;
        @(negedge aclk);
        while (pending_results.size() != 0) @(negedge aclk);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    task automatic write_reg(wms_cfg_t idx, logic [15:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(negedge aclk);
        cfg_we <= 1'b0;
        if (idx == CFG_TOLERANCE) tol_reg = value;
        else timeout_reg = value;
        @(negedge aclk);
    endtask

    task automatic test_idle_commands();
        send_op(OP_TICK);
        send_op(OP_START);
        send_op(OP_SPARE_6);
        send_op(OP_SPARE_7);
    endtask

    task automatic test_directed_pattern();
        send_append(32'sh7fffffff, 32'sh80000000, 16'd0);
        send_append(32'sh80000000, 32'sh7fffffff, 16'd2);
        send_append(32'sd0, 32'sd0, 16'hffff);
        send_op(OP_START);
        send_tick(32'sh7fffffff, 1'b1);
        send_tick(32'sh80000000, 1'b0);
        // far end of the range: the signed difference does not fit 32 bits
        send_tick(32'sh7fffffff, 1'b0);
        send_tick(32'sh80000000, 1'b0);
        send_op(OP_CANCEL);
        send_op(OP_START);
        send_op(OP_ESTOP);
        send_op(OP_START);
        send_append(32'sd5, -32'sd5, 16'd0);
        send_op(OP_CLEAR);
    endtask

    task automatic test_zero_timeout();
        wait_idle();
        write_reg(CFG_TIMEOUT, 16'd0);
        send_op(OP_CLEAR);
        send_append(32'sd100, 32'sd7, 16'd1);
        send_op(OP_START);
        send_tick(-32'sd100000, 1'b0);
        send_tick(-32'sd100000, 1'b0);
    endtask

    task automatic send_waypoint();
        command_t c;
        int       r;
        c = random_cmd(OP_APPEND);
        r = $urandom_range(99);
        if (r < 70) c.wp_dwell = 16'd0;
        else if (r < 95) c.wp_dwell = 16'($urandom_range(4, 1));
        send_command(c);
    endtask

    task automatic send_pattern_tick();
        command_t c;
        c = random_cmd(OP_TICK);
        if ($urandom_range(99) < 75) c.pos = near_position();
        c.rot_busy = ($urandom_range(99) < 25);
        send_command(c);
    endtask

    task automatic test_random_patterns(int n_items);
        int first;
        int ticks;
        int r;
        first = items_sent;
        while (items_sent - first < n_items) begin
            if ($urandom_range(99) < 12) begin
                send_op(3'($urandom_range(7)));
            end else begin
                send_op(OP_CLEAR);
                repeat ($urandom_range(6, 1)) send_waypoint();
                send_op(OP_START);
                ticks = 0;
                while (run_flag && ticks < 60) begin
                    r = $urandom_range(99);
                    if (r < 2) send_op(OP_CANCEL);
                    else if (r < 4) send_op(OP_ESTOP);
                    else if (r < 7) send_waypoint();
                    else if (r < 8) send_op(OP_START);
                    else if (r < 9) send_op(OP_CLEAR);
                    else send_pattern_tick();
                    ticks++;
                end
                repeat ($urandom_range(3, 0)) send_pattern_tick();
            end
        end
    endtask

    task automatic test_table_full();
        command_t c;
        int       ticks;
        send_op(OP_CLEAR);
        repeat (WMS_TABLE_DEPTH + 6) begin
            c          = random_cmd(OP_APPEND);
            c.wp_dwell = 16'($urandom_range(1));
            send_command(c);
        end
        send_op(OP_START);
        ticks = 0;
        while (run_flag && ticks < 400) begin
            send_tick(tgt_linear, $urandom_range(99) < 10);
            ticks++;
        end
        send_op(OP_TICK);
    endtask

    task automatic test_output_stall();
        hold_request = 1'b1;
        test_random_patterns(40);
    endtask

    initial begin
        repeat (6) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        test_idle_commands();
        test_directed_pattern();
        test_zero_timeout();

        wait_idle();
        write_reg(CFG_TOLERANCE, 16'hffff);
        write_reg(CFG_TIMEOUT, 16'hffff);
        test_random_patterns(400);

        wait_idle();
        send_idle_pct = 61;
        recv_idle_pct = 33;
        write_reg(CFG_TOLERANCE, 16'($urandom_range(200, 1)));
        write_reg(CFG_TIMEOUT, 16'd1);
        test_random_patterns(200);
        test_table_full();
        wait_idle();
        write_reg(CFG_TIMEOUT, 16'($urandom_range(30, 2)));
        write_reg(CFG_TOLERANCE, 16'd0);
        test_random_patterns(200);

        wait_idle();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        write_reg(CFG_TOLERANCE, 16'($urandom_range(16'hffff, 0)));
        write_reg(CFG_TIMEOUT, WMS_TIMEOUT_RESET);
        test_output_stall();
        test_random_patterns(330);

        wait_idle();
        repeat (20) @(posedge aclk);
        if (error_count == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
